// File: hw/rtl/tbpd_pkg.sv
// Shared types, constants, pipeline timing and the exp table for the
// three-body potential block. No dependencies.
`timescale 1ns / 1ps

package tbpd_pkg;

    localparam int FRAC_BITS       = 24;
    localparam int EXP_TABLE_DEPTH = 256;
    localparam int EXP_IDX_BITS    = $clog2(EXP_TABLE_DEPTH + 1);
    localparam int NOUT            = 10;
    localparam int OUT_W           = 48;

    localparam logic [63:0] LOG2E_Q62 = 64'h5C551D94AE0BF85D;
    localparam logic [63:0] LN2_Q48   = 64'h0000B17217F7D1CF;
    localparam logic [63:0] ONE_Q60   = 64'h1000000000000000;
    localparam logic [63:0] THIRD_Q60 = 64'h0555555555555555;

    // result shifts of the final products
    localparam int SH_BIG = 84 - FRAC_BITS;
    localparam int SH_SML = 44 - FRAC_BITS;

    // register indexes
    localparam logic [7:0] REG_ENERGY_SCALE = 8'd0;
    localparam logic [7:0] REG_DECAY        = 8'd1;
    localparam logic [7:0] REG_CUTOFF       = 8'd2;
    localparam logic [7:0] REG_INV_SCALE    = 8'd3;

    localparam logic [31:0] RST_ENERGY_SCALE = 32'd2984138;
    localparam logic [31:0] RST_DECAY        = 32'd20132659;
    localparam logic [31:0] RST_CUTOFF       = 32'd30198989;
    localparam logic [31:0] RST_INV_SCALE    = 32'd8007828;

    // unit latencies
    localparam int MUL_LAT   = 3;
    localparam int DIV_STEPS = 64;
    localparam int DIV_LAT   = DIV_STEPS + 1;

    // bond lane timing, cycles after the input register
    localparam int T_X    = 1;
    localparam int T_DN   = T_X + 1;
    localparam int T_Q    = T_DN + DIV_LAT;
    localparam int T_Y    = T_Q + MUL_LAT;
    localparam int T_IDX  = T_Y + 1;
    localparam int T_AB   = T_IDX + 1;
    localparam int T_DIFF = T_AB + 1;
    localparam int T_M    = T_DIFF + MUL_LAT;
    localparam int T_V    = T_M + 1;
    localparam int T_F    = T_V + 1;
    localparam int T_FQ   = T_F + MUL_LAT;
    localparam int T_FQ2  = T_FQ + MUL_LAT;
    localparam int T_P    = T_FQ2 + DIV_LAT;
    localparam int T_MAG  = T_FQ2 + 1;
    localparam int T_SMAG = T_MAG + MUL_LAT;
    localparam int T_X1   = T_SMAG + DIV_LAT;
    localparam int T_X2   = T_X1 + MUL_LAT;
    localparam int T_H    = T_X2 + DIV_LAT;
    localparam int BOND_LAT = T_H;
    localparam int COMB_LAT = 2 * MUL_LAT + 1;
    localparam int PIPE_LAT = BOND_LAT + COMB_LAT;

    typedef struct packed {
        logic [31:0] energy_scale;
        logic [31:0] decay;
        logic [31:0] cutoff;
        logic [31:0] inv_scale;
    } cfg_t;

    typedef struct packed {
        logic [63:0] f;
        logic [63:0] p;
        logic [63:0] h;
        logic        hneg;
    } bond_out_t;

    typedef logic [NOUT-1:0][OUT_W-1:0] result_t;

    typedef logic [63:0] exp_tab_t [0:EXP_TABLE_DEPTH];

    // 2^(-k/DEPTH) in Q.60 from a Taylor series of exp(-k*ln2/DEPTH) to order 24
    function automatic exp_tab_t build_exp_tab();
        exp_tab_t    tab;
        logic [127:0] prod;
        logic [127:0] targ;
        logic [63:0] t;
        logic [63:0] sum;
        logic [63:0] term;
        for (int k = 0; k <= EXP_TABLE_DEPTH; k++) begin
            targ = (128'(k) * 128'(LN2_Q48)) / EXP_TABLE_DEPTH;
            t    = 64'(targ << 12);
            sum  = ONE_Q60;
            term = ONE_Q60;
            for (int n = 1; n <= 24; n++) begin
                prod = (128'(term) * 128'(t)) >> 60;
                term = (prod[127:64] != 64'd0) ? '1 : prod[63:0];
                term = term / 64'(n);
                if ((n % 2) == 1)
                    sum = (sum >= term) ? sum - term : 64'd0;
                else
                    sum = sum + term;
            end
            tab[k] = sum;
        end
        return tab;
    endfunction

    localparam exp_tab_t EXP_TAB = build_exp_tab();

    // sign and clamp a magnitude into a 48-bit two's complement field
    function automatic logic [OUT_W-1:0] emit(input logic [63:0] mag, input logic neg);
        logic [63:0] m;
        m = mag;
        if (neg) begin
            if (m > (64'd1 << (OUT_W - 1)))
                m = 64'd1 << (OUT_W - 1);
            m = 64'd0 - m;
        end else if (m > ((64'd1 << (OUT_W - 1)) - 64'd1)) begin
            m = (64'd1 << (OUT_W - 1)) - 64'd1;
        end
        return m[OUT_W-1:0];
    endfunction

endpackage

// File: hw/rtl/tbpd_mul.sv
// Pipelined 64x64 multiply, floor(a*b / 2^sh) saturated to 64 bits.
// Three stages: 32x32 partials, 128-bit sum, shift and clamp. Uses tbpd_pkg.
`timescale 1ns / 1ps

module tbpd_mul (
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] a,
    input  logic [63:0] b,
    input  logic [6:0]  sh,
    output logic [63:0] p
);
    import tbpd_pkg::*;

    logic [63:0]  p00_reg, p01_reg, p10_reg, p11_reg;
    logic [127:0] sum_reg;
    logic [63:0]  p_reg;
    logic [127:0] shifted;

    assign shifted = sum_reg >> sh;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p00_reg <= 64'(a[31:0])  * 64'(b[31:0]);
            p01_reg <= 64'(a[31:0])  * 64'(b[63:32]);
            p10_reg <= 64'(a[63:32]) * 64'(b[31:0]);
            p11_reg <= 64'(a[63:32]) * 64'(b[63:32]);
            sum_reg <= 128'(p00_reg) + (128'(p01_reg) << 32) + (128'(p10_reg) << 32)
                     + (128'(p11_reg) << 64);
            p_reg   <= (shifted[127:64] != 64'd0) ? '1 : shifted[63:0];
        end
    end

    assign p = p_reg;

endmodule

// File: hw/rtl/tbpd_div.sv
// Pipelined divider, floor(num * 2^sh / den) saturated to 64 bits.
// One setup stage and one restoring step per stage. Uses tbpd_pkg.
`timescale 1ns / 1ps

module tbpd_div (
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] num,
    input  logic [63:0] den,
    input  logic [5:0]  sh,
    output logic [63:0] quo
);
    import tbpd_pkg::*;

    logic [63:0] rem_reg [0:DIV_STEPS];
    logic [63:0] lo_reg  [0:DIV_STEPS];
    logic [63:0] den_reg [0:DIV_STEPS];
    logic [63:0] q_reg   [0:DIV_STEPS];
    logic        sat_reg [0:DIV_STEPS];

    logic [63:0] rem_next [0:DIV_STEPS-1];
    logic [63:0] q_next   [0:DIV_STEPS-1];
    logic [64:0] trial    [0:DIV_STEPS-1];
    logic [127:0] wide;

    assign wide = {64'd0, num} << sh;

    always_comb
    begin
        for (int i = 0; i < DIV_STEPS; i++)
        begin
            trial[i] = {rem_reg[i], lo_reg[i][63]};
            if (trial[i] >= {1'b0, den_reg[i]})
            begin
                rem_next[i] = 64'(trial[i] - {1'b0, den_reg[i]});
                q_next[i]   = {q_reg[i][62:0], 1'b1};
            end
            else
            begin
                rem_next[i] = trial[i][63:0];
                q_next[i]   = {q_reg[i][62:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= wide[127:64];
            lo_reg[0]  <= wide[63:0];
            den_reg[0] <= den;
            q_reg[0]   <= 64'd0;
            sat_reg[0] <= (wide[127:64] >= den);
            for (int i = 0; i < DIV_STEPS; i++)
            begin
                rem_reg[i+1] <= rem_next[i];
                lo_reg[i+1]  <= {lo_reg[i][62:0], 1'b0};
                den_reg[i+1] <= den_reg[i];
                q_reg[i+1]   <= q_next[i];
                sat_reg[i+1] <= sat_reg[i];
            end
        end
    end

    assign quo = sat_reg[DIV_STEPS] ? '1 : q_reg[DIV_STEPS];

endmodule

// File: hw/rtl/tbpd_bond.sv
// One bond lane: cutoff gap, exp factor f and its first and second radial
// derivatives. Uses tbpd_pkg, tbpd_mul, tbpd_div.
`timescale 1ns / 1ps

module tbpd_bond (
    input  logic                clk,
    input  logic                en,
    input  tbpd_pkg::cfg_t      cfg,
    input  logic [31:0]         bond_len,
    output tbpd_pkg::bond_out_t res
);
    import tbpd_pkg::*;

    localparam int L_Q    = T_FQ - T_Q;
    localparam int L_DN   = T_X2 - T_DN;
    localparam int L_IN   = T_H - T_DN;
    localparam int L_DEAD = T_H - T_IDX;
    localparam int L_T    = T_DIFF - T_IDX;
    localparam int L_N    = T_V - T_IDX;
    localparam int L_A    = T_M - T_AB;
    localparam int L_GE   = T_M - T_DIFF;
    localparam int L_FQ   = T_FQ2 - T_FQ;
    localparam int L_F    = T_H - T_F;
    localparam int L_P    = T_H - T_P;
    localparam int L_HN   = T_H - T_MAG;
    localparam int POS_W  = 32 + $clog2(EXP_TABLE_DEPTH + 1);

    logic [63:0] s64;
    logic [63:0] lim;
    logic [63:0] x_reg;
    logic [63:0] dn_reg;
    logic        inside_reg;

    logic [63:0] q, y, m_int, fq, fq2, sfq, smag, x1, x2, p, h;

    logic [POS_W-1:0]      pos;
    logic [EXP_IDX_BITS-1:0] idx_reg;
    logic [31:0]           t_reg;
    logic [5:0]            n_reg;
    logic                  dead_reg;
    logic [63:0]           a_reg, b_reg;
    logic [63:0]           diff_reg;
    logic                  ge_reg;
    logic [63:0]           v_reg, fv_reg;
    logic [63:0]           two_fq;
    logic [63:0]           mag_reg;
    logic                  hneg_reg;
    logic                  zero;

    logic [63:0]  q_d    [0:L_Q-1];
    logic [63:0]  dn_d   [0:L_DN-1];
    logic         in_d   [0:L_IN-1];
    logic         dead_d [0:L_DEAD-1];
    logic [31:0]  t_d    [0:L_T-1];
    logic [5:0]   n_d    [0:L_N-1];
    logic [63:0]  a_d    [0:L_A-1];
    logic         ge_d   [0:L_GE-1];
    logic [63:0]  fq_d   [0:L_FQ-1];
    logic [63:0]  f_d    [0:L_F-1];
    logic [63:0]  p_d    [0:L_P-1];
    logic         hn_d   [0:L_HN-1];

    assign s64    = 64'(cfg.inv_scale);
    assign lim    = 64'(cfg.cutoff) << FRAC_BITS;
    assign pos    = POS_W'(y[31:0]) * POS_W'(EXP_TABLE_DEPTH);
    assign two_fq = {fq_d[L_FQ-1][62:0], 1'b0};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg      <= 64'(bond_len) * s64;
            dn_reg     <= lim - x_reg;
            inside_reg <= (x_reg < lim);
            // exp index, fraction and integer shift
            dead_reg   <= (y[63:32] >= 32'd61);
            n_reg      <= y[37:32];
            idx_reg    <= EXP_IDX_BITS'(pos[POS_W-1:32]);
            t_reg      <= pos[31:0];
            a_reg      <= EXP_TAB[idx_reg];
            b_reg      <= EXP_TAB[idx_reg + EXP_IDX_BITS'(1)];
            ge_reg     <= (a_reg >= b_reg);
            diff_reg   <= (a_reg >= b_reg) ? a_reg - b_reg : b_reg - a_reg;
            v_reg      <= ge_d[L_GE-1] ? a_d[L_A-1] - m_int : a_d[L_A-1] + m_int;
            fv_reg     <= v_reg >> n_d[L_N-1];
            if (fq2 >= two_fq)
            begin
                mag_reg  <= fq2 - two_fq;
                hneg_reg <= 1'b0;
            end
            else
            begin
                mag_reg  <= two_fq - fq2;
                hneg_reg <= 1'b1;
            end

            q_d[0]    <= q;
            dn_d[0]   <= dn_reg;
            in_d[0]   <= inside_reg;
            dead_d[0] <= dead_reg;
            t_d[0]    <= t_reg;
            n_d[0]    <= n_reg;
            a_d[0]    <= a_reg;
            ge_d[0]   <= ge_reg;
            fq_d[0]   <= fq;
            f_d[0]    <= fv_reg;
            p_d[0]    <= p;
            hn_d[0]   <= hneg_reg;
            for (int i = 1; i < L_Q; i++)    q_d[i]    <= q_d[i-1];
            for (int i = 1; i < L_DN; i++)   dn_d[i]   <= dn_d[i-1];
            for (int i = 1; i < L_IN; i++)   in_d[i]   <= in_d[i-1];
            for (int i = 1; i < L_DEAD; i++) dead_d[i] <= dead_d[i-1];
            for (int i = 1; i < L_T; i++)    t_d[i]    <= t_d[i-1];
            for (int i = 1; i < L_N; i++)    n_d[i]    <= n_d[i-1];
            for (int i = 1; i < L_A; i++)    a_d[i]    <= a_d[i-1];
            for (int i = 1; i < L_GE; i++)   ge_d[i]   <= ge_d[i-1];
            for (int i = 1; i < L_FQ; i++)   fq_d[i]   <= fq_d[i-1];
            for (int i = 1; i < L_F; i++)    f_d[i]    <= f_d[i-1];
            for (int i = 1; i < L_P; i++)    p_d[i]    <= p_d[i-1];
            for (int i = 1; i < L_HN; i++)   hn_d[i]   <= hn_d[i-1];
        end
    end

    // q = decay / gap
    tbpd_div u_div_q (.clk(clk), .en(en), .num(64'(cfg.decay)), .den(dn_reg),
                      .sh(6'(FRAC_BITS + 32)), .quo(q));
    tbpd_mul u_mul_y (.clk(clk), .en(en), .a(q), .b(LOG2E_Q62), .sh(7'd62), .p(y));
    tbpd_mul u_mul_i (.clk(clk), .en(en), .a(diff_reg), .b(64'(t_d[L_T-1])),
                      .sh(7'd32), .p(m_int));
    tbpd_mul u_mul_fq (.clk(clk), .en(en), .a(fv_reg), .b(q_d[T_F-T_Q-1]),
                       .sh(7'd32), .p(fq));
    tbpd_mul u_mul_fq2 (.clk(clk), .en(en), .a(fq), .b(q_d[L_Q-1]), .sh(7'd32), .p(fq2));
    tbpd_mul u_mul_sfq (.clk(clk), .en(en), .a(s64), .b(fq), .sh(7'd30), .p(sfq));
    tbpd_div u_div_p (.clk(clk), .en(en), .num(sfq), .den(dn_d[T_FQ2-T_DN-1]),
                      .sh(6'(FRAC_BITS + 10)), .quo(p));
    tbpd_mul u_mul_smag (.clk(clk), .en(en), .a(s64), .b(mag_reg), .sh(7'd30), .p(smag));
    tbpd_div u_div_x1 (.clk(clk), .en(en), .num(smag), .den(dn_d[T_SMAG-T_DN-1]),
                       .sh(6'(FRAC_BITS + 10)), .quo(x1));
    tbpd_mul u_mul_x2 (.clk(clk), .en(en), .a(x1), .b(s64), .sh(7'(FRAC_BITS)), .p(x2));
    tbpd_div u_div_h (.clk(clk), .en(en), .num(x2), .den(dn_d[L_DN-1]),
                      .sh(6'(2 * FRAC_BITS)), .quo(h));

    // outside the cutoff or decayed past the shift range: all terms vanish
    assign zero     = !in_d[L_IN-1] || dead_d[L_DEAD-1];
    assign res.f    = zero ? 64'd0 : f_d[L_F-1];
    assign res.p    = zero ? 64'd0 : p_d[L_P-1];
    assign res.h    = zero ? 64'd0 : h;
    assign res.hneg = zero ? 1'b0  : hn_d[L_HN-1];

endmodule

// File: hw/rtl/tbpd_comb.sv
// Angular factor and the ten cross products of energy, gradient and Hessian.
// Uses tbpd_pkg and tbpd_mul.
`timescale 1ns / 1ps

module tbpd_comb (
    input  logic                clk,
    input  logic                en,
    input  logic [31:0]         energy_scale,
    input  logic [31:0]         cos_angle,
    input  tbpd_pkg::bond_out_t b1,
    input  tbpd_pkg::bond_out_t b2,
    output tbpd_pkg::result_t   result
);
    import tbpd_pkg::*;

    localparam int L_COS = BOND_LAT - 1 - 2 * MUL_LAT;
    localparam int L_SGN = 4 * MUL_LAT;
    localparam int L_B   = MUL_LAT;

    logic [31:0] cos_d  [0:L_COS-1];
    logic        uneg_d [0:L_SGN-1];
    logic [63:0] bu_d   [0:L_B-1];
    logic [63:0] f2_d   [0:L_B-1];
    logic [63:0] p1_d   [0:L_B-1];
    logic [63:0] p2_d   [0:L_B-1];
    logic [63:0] h1_d   [0:L_B-1];
    logic [63:0] h2_d   [0:L_B-1];
    logic        h1n_d  [0:2*L_B-1];
    logic        h2n_d  [0:2*L_B-1];

    logic [31:0] cs;
    logic [63:0] cm;
    logic [63:0] umag_c;
    logic        uneg_c;
    logic [63:0] umag_reg;
    logic        uneg_reg;
    logic [63:0] g, bg, bu, b2f;
    logic [63:0] l_bg1, l_bg2, l_bu1, l_bu2, l_b21, l_bgp1;
    logic [NOUT-1:0][63:0] l2;
    result_t     result_reg;

    assign cs  = cos_d[L_COS-1];
    assign cm  = 64'(33'h1_0000_0000 - {1'b0, cs}) << 30;
    assign b2f = 64'(energy_scale) << 29;

    always_comb
    begin
        if (cs[31])
        begin
            if (cm > THIRD_Q60)
            begin
                umag_c = cm - THIRD_Q60;
                uneg_c = 1'b1;
            end
            else
            begin
                umag_c = THIRD_Q60 - cm;
                uneg_c = 1'b0;
            end
        end
        else
        begin
            umag_c = (64'(cs) << 30) + THIRD_Q60;
            uneg_c = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            umag_reg <= umag_c;
            uneg_reg <= uneg_c;
            cos_d[0]  <= cos_angle;
            uneg_d[0] <= uneg_reg;
            bu_d[0]   <= bu;
            f2_d[0]   <= b2.f;
            p1_d[0]   <= b1.p;
            p2_d[0]   <= b2.p;
            h1_d[0]   <= b1.h;
            h2_d[0]   <= b2.h;
            h1n_d[0]  <= b1.hneg;
            h2n_d[0]  <= b2.hneg;
            for (int i = 1; i < L_COS; i++) cos_d[i]  <= cos_d[i-1];
            for (int i = 1; i < L_SGN; i++) uneg_d[i] <= uneg_d[i-1];
            for (int i = 1; i < L_B; i++)
            begin
                bu_d[i] <= bu_d[i-1];
                f2_d[i] <= f2_d[i-1];
                p1_d[i] <= p1_d[i-1];
                p2_d[i] <= p2_d[i-1];
                h1_d[i] <= h1_d[i-1];
                h2_d[i] <= h2_d[i-1];
            end
            for (int i = 1; i < 2 * L_B; i++)
            begin
                h1n_d[i] <= h1n_d[i-1];
                h2n_d[i] <= h2n_d[i-1];
            end
            result_reg[0] <= emit(l2[0] >> SH_SML, 1'b0);
            result_reg[1] <= emit(l2[1], 1'b1);
            result_reg[2] <= emit(l2[2], 1'b1);
            result_reg[3] <= emit(l2[3] >> SH_SML, uneg_d[L_SGN-1]);
            result_reg[4] <= emit(l2[4], h1n_d[2*L_B-1]);
            result_reg[5] <= emit(l2[5], h2n_d[2*L_B-1]);
            result_reg[6] <= emit(l2[6] >> SH_SML, 1'b0);
            result_reg[7] <= emit(l2[7], 1'b0);
            result_reg[8] <= emit(l2[8], !uneg_d[L_SGN-1]);
            result_reg[9] <= emit(l2[9], !uneg_d[L_SGN-1]);
        end
    end

    // angular factors
    tbpd_mul u_g  (.clk(clk), .en(en), .a(umag_reg), .b(umag_reg), .sh(7'd60), .p(g));
    tbpd_mul u_bg (.clk(clk), .en(en), .a(64'(energy_scale)), .b(g), .sh(7'd32), .p(bg));
    tbpd_mul u_bu (.clk(clk), .en(en), .a(64'(energy_scale)), .b({umag_reg[62:0], 1'b0}),
                   .sh(7'd32), .p(bu));

    // first level
    tbpd_mul u_l1a (.clk(clk), .en(en), .a(bg), .b(b1.f), .sh(7'd60), .p(l_bg1));
    tbpd_mul u_l1b (.clk(clk), .en(en), .a(bg), .b(b2.f), .sh(7'd60), .p(l_bg2));
    tbpd_mul u_l1c (.clk(clk), .en(en), .a(bu_d[L_B-1]), .b(b1.f), .sh(7'd60), .p(l_bu1));
    tbpd_mul u_l1d (.clk(clk), .en(en), .a(bu_d[L_B-1]), .b(b2.f), .sh(7'd60), .p(l_bu2));
    tbpd_mul u_l1e (.clk(clk), .en(en), .a(b2f), .b(b1.f), .sh(7'd60), .p(l_b21));
    tbpd_mul u_l1f (.clk(clk), .en(en), .a(bg), .b(b1.p), .sh(7'd40), .p(l_bgp1));

    // second level
    tbpd_mul u_o0 (.clk(clk), .en(en), .a(l_bg1), .b(f2_d[L_B-1]), .sh(7'd60), .p(l2[0]));
    tbpd_mul u_o1 (.clk(clk), .en(en), .a(l_bg2), .b(p1_d[L_B-1]), .sh(7'(SH_BIG)), .p(l2[1]));
    tbpd_mul u_o2 (.clk(clk), .en(en), .a(l_bg1), .b(p2_d[L_B-1]), .sh(7'(SH_BIG)), .p(l2[2]));
    tbpd_mul u_o3 (.clk(clk), .en(en), .a(l_bu1), .b(f2_d[L_B-1]), .sh(7'd60), .p(l2[3]));
    tbpd_mul u_o4 (.clk(clk), .en(en), .a(l_bg2), .b(h1_d[L_B-1]), .sh(7'(SH_BIG)), .p(l2[4]));
    tbpd_mul u_o5 (.clk(clk), .en(en), .a(l_bg1), .b(h2_d[L_B-1]), .sh(7'(SH_BIG)), .p(l2[5]));
    tbpd_mul u_o6 (.clk(clk), .en(en), .a(l_b21), .b(f2_d[L_B-1]), .sh(7'd60), .p(l2[6]));
    tbpd_mul u_o7 (.clk(clk), .en(en), .a(l_bgp1), .b(p2_d[L_B-1]), .sh(7'(SH_BIG)),
                   .p(l2[7]));
    tbpd_mul u_o8 (.clk(clk), .en(en), .a(l_bu2), .b(p1_d[L_B-1]), .sh(7'(SH_BIG)), .p(l2[8]));
    tbpd_mul u_o9 (.clk(clk), .en(en), .a(l_bu1), .b(p2_d[L_B-1]), .sh(7'(SH_BIG)), .p(l2[9]));

    assign result = result_reg;

endmodule

// File: hw/rtl/three_body_potential_derivatives.sv
// Top level of the three-body potential block: config registers, input
// register, two bond lanes, cross products, output queue. Uses tbpd_pkg, tbpd_bond, tbpd_comb.
`timescale 1ns / 1ps
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+----------------------------------------
//  s_      | in  | s_tvalid/s_tready  | s_tdata: dist_first, dist_second, cos
//  m_      | out | m_tvalid/m_tready  | m_tdata: energy .. h_second_cos
//  cfg_    | in  | cfg_valid/cfg_ready| cfg_index, cfg_data (ready always high)
//
// One bond triple per cycle while the output queue is not full. Pipeline depth
// is set by three dependent dividers in each bond lane (gap quotient, then
// two for the curvature).
// Reset clears the config to defaults and all valid bits; the exp table is
// constant logic and needs no fill.
// A two-entry output queue takes results; the pipeline advances whenever the
// queue is not full, so a stalled output costs no transfer and repeats none.

module three_body_potential_derivatives (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,   // dist_first[31:0], dist_second[63:32], cos_angle[95:64]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [479:0] m_tdata,   // energy, d_first, d_second, d_cos, h_first_first,
                                    // h_second_second, h_cos_cos, h_first_second,
                                    // h_first_cos, h_second_cos; 48 bits each
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [7:0]   cfg_index,
    input  logic [31:0]  cfg_data
);
    import tbpd_pkg::*;

    cfg_t        cfg_reg;
    logic        en;
    logic [31:0] d1_reg, d2_reg, cos_reg;
    logic        valid_reg [0:PIPE_LAT];
    bond_out_t   bond1, bond2;
    result_t     result;

    result_t     fifo_mem [0:1];
    logic        wr_ptr_reg, rd_ptr_reg;
    logic [1:0]  count_reg;
    logic        push, pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.energy_scale <= RST_ENERGY_SCALE;
            cfg_reg.decay        <= RST_DECAY;
            cfg_reg.cutoff       <= RST_CUTOFF;
            cfg_reg.inv_scale    <= RST_INV_SCALE;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_ENERGY_SCALE: cfg_reg.energy_scale <= cfg_data;
                REG_DECAY:        cfg_reg.decay        <= cfg_data;
                REG_CUTOFF:       cfg_reg.cutoff       <= cfg_data;
                REG_INV_SCALE:    cfg_reg.inv_scale    <= cfg_data;
                default:          ;
            endcase
        end
    end

    // whole pipeline moves together; registered queue level breaks the path
    assign en       = (count_reg != 2'd2);
    assign s_tready = en;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d1_reg  <= s_tdata[31:0];
            d2_reg  <= s_tdata[63:32];
            cos_reg <= s_tdata[95:64];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= PIPE_LAT; i++)
                valid_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            valid_reg[0] <= s_tvalid;
            for (int i = 1; i <= PIPE_LAT; i++)
                valid_reg[i] <= valid_reg[i-1];
        end
    end

    tbpd_bond u_bond1 (.clk(clk), .en(en), .cfg(cfg_reg), .bond_len(d1_reg), .res(bond1));
    tbpd_bond u_bond2 (.clk(clk), .en(en), .cfg(cfg_reg), .bond_len(d2_reg), .res(bond2));

    // cosine enters the cross stage delayed to meet the bond results
    tbpd_comb u_comb (
        .clk         (clk),
        .en          (en),
        .energy_scale(cfg_reg.energy_scale),
        .cos_angle   (cos_reg),
        .b1          (bond1),
        .b2          (bond2),
        .result      (result)
    );

    assign push = en && valid_reg[PIPE_LAT];
    assign pop  = m_tvalid && m_tready;

    always_ff @(posedge clk)
    begin
        if (push)
            fifo_mem[wr_ptr_reg] <= result;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

    assign m_tvalid = (count_reg != 2'd0);
    assign m_tdata  = fifo_mem[rd_ptr_reg];

endmodule
